[rtl/core/xml_entity_unescape_stream_defines.svh]
// assertion macros shared by the checker of the entity decoder
// no dependencies
`ifndef XML_ENTITY_UNESCAPE_STREAM_DEFINES_SVH
`define XML_ENTITY_UNESCAPE_STREAM_DEFINES_SVH

// same-cycle implication
`define XEU_ASSERT_NOW(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define XEU_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/xeu_pkg.sv]
// shared types and constants of the entity decoder
// no dependencies
`default_nettype none

package xeu_pkg;

    localparam int MAX_NAME_LEN_DEF = 9;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [30:0] CP_QUOT  = 31'h22;
    localparam logic [30:0] CP_AMP   = 31'h26;
    localparam logic [30:0] CP_APOS  = 31'h27;
    localparam logic [30:0] CP_LT    = 31'h3c;
    localparam logic [30:0] CP_GT    = 31'h3e;
    localparam logic [30:0] CP_LIMIT = 31'h7fffffff;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN,
        ST_DEC,
        ST_NUM,
        ST_CHKZ,
        ST_UTF,
        ST_FAIL,
        ST_REPLAY,
        ST_EOT,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        EM_HEAD,
        EM_AMP,
        EM_UTF,
        EM_MARK
    } t_emit;

    typedef struct packed {
        logic  q_load;
        logic  q_pop;
        logic  push_cur;
        logic  push_buf;
        logic  set_coll;
        logic  clr_coll;
        logic  buf_wr;
        logic  rcnt_load;
        logic  dec_start;
        logic  num_step;
        logic  utf_step;
        logic  emit;
        t_emit esel;
        logic  run_clear;
        logic  finish;
    } t_cmd;

    typedef struct packed {
        logic q_empty;
        logic head_amp;
        logic head_semi;
        logic coll;
        logic cnt_full;
        logic rcnt_zero;
        logic named_hit;
        logic num_ok;
        logic dig_bad;
        logic num_last;
        logic cp_zero;
        logic utf_last;
        logic emit_ok;
        logic hold_v;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

[rtl/core/xeu_ctrl.sv]
// controller state machine of the entity decoder
// depends on xeu_pkg
`default_nettype none

module xeu_ctrl import xeu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_end_of_text,
    output logic      o_in_stall,
    input  t_stat     i_stat,
    output t_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_eot, n_eot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_eot   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eot   <= n_eot;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_eot      = r_eot;
        o_cmd      = '0;
        o_cmd.esel = EM_HEAD;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.run_clear = 1'b1;
                    if (i_end_of_text) begin
                        n_eot   = 1'b1;
                        n_state = ST_EOT;
                    end else begin
                        n_eot        = 1'b0;
                        o_cmd.q_load = 1'b1;
                        n_state      = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (i_stat.q_empty) begin
                    n_state = r_eot ? ST_EOT : ST_FINISH;
                end else if (!i_stat.coll) begin
                    if (i_stat.head_amp) begin
                        o_cmd.q_pop    = 1'b1;
                        o_cmd.set_coll = 1'b1;
                    end else if (i_stat.emit_ok) begin
                        o_cmd.q_pop = 1'b1;
                        o_cmd.emit  = 1'b1;
                        o_cmd.esel  = EM_HEAD;
                    end
                end else begin
                    o_cmd.q_pop = 1'b1;
                    if (i_stat.head_semi) begin
                        n_state = ST_DEC;
                    end else if (!i_stat.cnt_full) begin
                        o_cmd.buf_wr = 1'b1;
                    end else begin
                        n_state = ST_FAIL;
                    end
                end
            end
            ST_DEC: begin
                o_cmd.dec_start = 1'b1;
                if (i_stat.named_hit) begin
                    n_state = ST_UTF;
                end else if (i_stat.num_ok) begin
                    n_state = ST_NUM;
                end else begin
                    n_state = ST_FAIL;
                end
            end
            ST_NUM: begin
                if (i_stat.dig_bad) begin
                    n_state = ST_FAIL;
                end else begin
                    o_cmd.num_step = 1'b1;
                    if (i_stat.num_last) begin
                        n_state = ST_CHKZ;
                    end
                end
            end
            ST_CHKZ: begin
                n_state = i_stat.cp_zero ? ST_FAIL : ST_UTF;
            end
            ST_UTF: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.esel = EM_UTF;
                    if (i_stat.utf_last) begin
                        o_cmd.clr_coll = 1'b1;
                        n_state        = ST_RUN;
                    end else begin
                        o_cmd.utf_step = 1'b1;
                    end
                end
            end
            ST_FAIL: begin
                // literal ampersand, then the ending byte goes back in front
                if (i_stat.emit_ok) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.esel      = EM_AMP;
                    o_cmd.push_cur  = 1'b1;
                    o_cmd.clr_coll  = 1'b1;
                    o_cmd.rcnt_load = 1'b1;
                    n_state         = ST_REPLAY;
                end
            end
            ST_REPLAY: begin
                if (i_stat.rcnt_zero) begin
                    n_state = ST_RUN;
                end else begin
                    o_cmd.push_buf = 1'b1;
                end
            end
            ST_EOT: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.coll) begin
                        o_cmd.esel      = EM_AMP;
                        o_cmd.clr_coll  = 1'b1;
                        o_cmd.rcnt_load = 1'b1;
                        n_state         = ST_REPLAY;
                    end else begin
                        o_cmd.esel = EM_MARK;
                        n_state    = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!i_stat.hold_v) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/xeu_dp.sv]
// datapath of the entity decoder: replay queue, name buffer, decoder, utf-8 encoder
// and output registers; depends on xeu_pkg
`default_nettype none

module xeu_dp import xeu_pkg::*; #(
    parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_in_byte,
    input  t_cmd            i_cmd,
    output t_stat           o_stat,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_text_done,
    output logic            o_last_of_run
);

    localparam int QLEN   = MAX_NAME_LEN + 1;
    localparam int MAXOUT = MAX_NAME_LEN + 2;
    localparam int CW     = $clog2(MAX_NAME_LEN + 1);
    localparam int QLW    = $clog2(QLEN + 1);
    localparam int BIW    = $clog2(MAX_NAME_LEN);
    localparam int NW     = $clog2(MAXOUT + 1);

    // replay queue, head at entry 0
    logic [7:0]     r_q [QLEN];
    logic [QLW-1:0] r_qlen;
    logic [7:0]     r_cur;
    logic           r_coll;
    logic [7:0]     r_buf [MAX_NAME_LEN];
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  r_rcnt;
    logic [CW-1:0]  r_idx;
    logic           r_hex;
    logic [30:0]    r_cp;
    logic [2:0]     r_j;
    logic [NW-1:0]  r_n;

    logic       r_hv, r_hbv, r_hd;
    logic [7:0] r_hb;
    logic       r_ov, r_obv, r_od, r_ol;
    logic [7:0] r_ob;

    logic [7:0]    head;
    logic [CW-1:0] rcnt_m1;
    logic [BIW-1:0] rd_addr;
    logic [7:0]    rd_byte;
    logic          capped, out_free;
    logic          is_hex, is_dec, named_hit;
    logic [30:0]   named_cp;
    logic [CW-1:0] start;
    logic          dig_ok;
    logic [3:0]    dig;
    logic [35:0]   prod;
    logic [30:0]   acc_next;
    logic [2:0]    ulen, uk;
    logic [7:0]    ulead;
    logic [4:0]    ush;
    logic [31:0]   ushifted;
    logic [7:0]    ubyte;
    logic [7:0]    ebyte;
    logic          evalid, edone;
    logic [7:0]    push_val;
    logic          push;

    assign head     = r_q[0];
    assign rcnt_m1  = r_rcnt - 1'b1;
    assign rd_addr  = i_cmd.push_buf ? rcnt_m1[BIW-1:0] : r_idx[BIW-1:0];
    assign rd_byte  = r_buf[rd_addr];
    assign capped   = (r_n >= NW'(MAXOUT));
    assign out_free = !r_ov || !i_out_stall;

    // named entities and numeric prefixes
    always_comb begin
        named_hit = 1'b0;
        named_cp  = '0;
        if (r_cnt == CW'(4) && r_buf[0] == "q" && r_buf[1] == "u"
                && r_buf[2] == "o" && r_buf[3] == "t") begin
            named_hit = 1'b1;
            named_cp  = CP_QUOT;
        end else if (r_cnt == CW'(3) && r_buf[0] == "a" && r_buf[1] == "m"
                && r_buf[2] == "p") begin
            named_hit = 1'b1;
            named_cp  = CP_AMP;
        end else if (r_cnt == CW'(4) && r_buf[0] == "a" && r_buf[1] == "p"
                && r_buf[2] == "o" && r_buf[3] == "s") begin
            named_hit = 1'b1;
            named_cp  = CP_APOS;
        end else if (r_cnt == CW'(2) && r_buf[0] == "l" && r_buf[1] == "t") begin
            named_hit = 1'b1;
            named_cp  = CP_LT;
        end else if (r_cnt == CW'(2) && r_buf[0] == "g" && r_buf[1] == "t") begin
            named_hit = 1'b1;
            named_cp  = CP_GT;
        end
    end

    assign is_hex = (r_cnt >= CW'(2)) && r_buf[0] == CH_HASH && r_buf[1] == CH_X;
    assign is_dec = (r_cnt >= CW'(1)) && r_buf[0] == CH_HASH;
    assign start  = is_hex ? CW'(2) : CW'(1);

    // one digit per cycle
    always_comb begin
        dig_ok = 1'b0;
        dig    = '0;
        if (rd_byte >= "0" && rd_byte <= "9") begin
            dig_ok = 1'b1;
            dig    = 4'(rd_byte - "0");
        end else if (r_hex && rd_byte >= "a" && rd_byte <= "f") begin
            dig_ok = 1'b1;
            dig    = 4'(rd_byte - "a" + 8'd10);
        end else if (r_hex && rd_byte >= "A" && rd_byte <= "F") begin
            dig_ok = 1'b1;
            dig    = 4'(rd_byte - "A" + 8'd10);
        end
    end

    assign prod = (r_hex ? {1'b0, r_cp, 4'b0} : ({4'b0, r_cp, 1'b0} + {2'b0, r_cp, 3'b0}))
                  + {32'b0, dig};
    assign acc_next = (prod > {5'b0, CP_LIMIT}) ? CP_LIMIT : prod[30:0];

    // utf-8 byte j of the code point
    always_comb begin
        if (r_cp < 31'h80) begin
            ulen = 3'd1; ulead = 8'h00;
        end else if (r_cp < 31'h800) begin
            ulen = 3'd2; ulead = 8'hc0;
        end else if (r_cp < 31'h10000) begin
            ulen = 3'd3; ulead = 8'he0;
        end else if (r_cp < 31'h200000) begin
            ulen = 3'd4; ulead = 8'hf0;
        end else if (r_cp < 31'h4000000) begin
            ulen = 3'd5; ulead = 8'hf8;
        end else begin
            ulen = 3'd6; ulead = 8'hfc;
        end
    end

    assign uk       = ulen - 3'd1 - r_j;
    assign ush      = {uk, 2'b0} + {1'b0, uk, 1'b0};
    assign ushifted = {1'b0, r_cp} >> ush;
    assign ubyte    = (r_j == 3'd0) ? (ulead | ushifted[7:0]) : {2'b10, ushifted[5:0]};

    always_comb begin
        evalid = 1'b1;
        edone  = 1'b0;
        case (i_cmd.esel)
            EM_HEAD: ebyte = head;
            EM_AMP:  ebyte = CH_AMP;
            EM_UTF:  ebyte = ubyte;
            EM_MARK: begin
                ebyte  = 8'h00;
                evalid = 1'b0;
                edone  = 1'b1;
            end
            default: ebyte = head;
        endcase
    end

    assign push     = i_cmd.push_cur || i_cmd.push_buf;
    assign push_val = i_cmd.push_buf ? rd_byte : r_cur;

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_load) begin
            r_q[0] <= i_in_byte;
        end else if (i_cmd.q_pop) begin
            for (int i = 0; i < QLEN - 1; i++) begin
                r_q[i] <= r_q[i+1];
            end
            r_cur <= head;
        end else if (push) begin
            // push to the front, the tail falls off when full
            for (int i = 1; i < QLEN; i++) begin
                r_q[i] <= r_q[i-1];
            end
            r_q[0] <= push_val;
        end
        if (i_cmd.buf_wr) begin
            r_buf[r_cnt[BIW-1:0]] <= head;
        end
        if (i_cmd.dec_start) begin
            r_cp  <= named_hit ? named_cp : '0;
            r_idx <= start;
            r_hex <= is_hex;
            r_j   <= '0;
        end else if (i_cmd.num_step) begin
            r_cp  <= acc_next;
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.utf_step) begin
            r_j <= r_j + 3'd1;
        end
        if (i_cmd.emit && !capped) begin
            r_hb  <= ebyte;
            r_hbv <= evalid;
            r_hd  <= edone;
        end
        if ((i_cmd.emit && !capped && r_hv) || (i_cmd.finish && r_hv)) begin
            r_ob  <= r_hb;
            r_obv <= r_hbv;
            r_od  <= r_hd;
            r_ol  <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= '0;
            r_coll <= 1'b0;
            r_cnt  <= '0;
            r_rcnt <= '0;
            r_n    <= '0;
            r_hv   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cmd.q_load) begin
                r_qlen <= QLW'(1);
            end else if (i_cmd.q_pop) begin
                r_qlen <= r_qlen - 1'b1;
            end else if (push && r_qlen != QLW'(QLEN)) begin
                r_qlen <= r_qlen + 1'b1;
            end
            if (i_cmd.set_coll) begin
                r_coll <= 1'b1;
                r_cnt  <= '0;
            end else if (i_cmd.clr_coll) begin
                r_coll <= 1'b0;
                r_cnt  <= '0;
            end else if (i_cmd.buf_wr) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.rcnt_load) begin
                r_rcnt <= r_cnt;
            end else if (i_cmd.push_buf) begin
                r_rcnt <= rcnt_m1;
            end
            if (i_cmd.run_clear) begin
                r_n <= '0;
            end else if (i_cmd.emit && !capped) begin
                r_n <= r_n + 1'b1;
            end
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if ((i_cmd.emit && !capped && r_hv) || (i_cmd.finish && r_hv)) begin
                r_ov <= 1'b1;
            end
            if (i_cmd.emit && !capped) begin
                r_hv <= 1'b1;
            end else if (i_cmd.finish) begin
                r_hv <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.q_empty   = (r_qlen == '0);
        o_stat.head_amp  = (head == CH_AMP);
        o_stat.head_semi = (head == CH_SEMI);
        o_stat.coll      = r_coll;
        o_stat.cnt_full  = (r_cnt >= CW'(MAX_NAME_LEN));
        o_stat.rcnt_zero = (r_rcnt == '0);
        o_stat.named_hit = named_hit;
        o_stat.num_ok    = (is_hex || is_dec) && (r_cnt > start);
        o_stat.dig_bad   = !dig_ok;
        o_stat.num_last  = (r_idx == r_cnt - 1'b1);
        o_stat.cp_zero   = (r_cp == '0);
        o_stat.utf_last  = (r_j == ulen - 3'd1);
        o_stat.emit_ok   = capped || !r_hv || out_free;
        o_stat.hold_v    = r_hv;
        o_stat.out_free  = out_free;
    end

    assign o_out_valid   = r_ov;
    assign o_out_byte    = r_ob;
    assign o_byte_valid  = r_obv;
    assign o_text_done   = r_od;
    assign o_last_of_run = r_ol;

endmodule

`default_nettype wire

[rtl/core/xml_entity_unescape_stream.sv]
// path: a plain byte passes queue, hold and output register; a stalled output holds it
// plain word: take, queue byte, drain check, finish, then the next word is taken;
// an entity end adds decode, a numeric one a step per digit and a zero check,
// each utf-8 byte a step; a failed entity adds the ampersand and a byte replay
// reset: synchronous active low; clears queue, entity state and output valid
// top level: joins xeu_ctrl and xeu_dp; depends on xeu_pkg
`default_nettype none

module xml_entity_unescape_stream import xeu_pkg::*; #(
    parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_text,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_text_done,
    output logic            o_last_of_run
);

    t_cmd  cmd;
    t_stat stat;

    xeu_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_end_of_text (i_end_of_text),
        .o_in_stall    (o_in_stall),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    xeu_dp #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_byte     (i_in_byte),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_text_done   (o_text_done),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

[rtl/core/xeu_checker.sv]
// port-level checks of the entity decoder, bound to the top level
// depends on xml_entity_unescape_stream_defines.svh
`default_nettype none
`include "xml_entity_unescape_stream_defines.svh"

module xeu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_byte_valid,
    input wire logic       o_text_done,
    input wire logic       o_last_of_run
);

    `XEU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_byte) && $stable(o_last_of_run), "stalled output word changed")
    `XEU_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken twice in a row")
    `XEU_ASSERT_NOW(a_marker_form, i_clk, i_rst_n, o_out_valid && o_text_done, !o_byte_valid && o_out_byte == 8'h00 && o_last_of_run, "bad end marker")
    `XEU_ASSERT_NOW(a_bare_is_marker, i_clk, i_rst_n, o_out_valid && !o_byte_valid, o_text_done, "empty word without end flag")

endmodule

bind xml_entity_unescape_stream xeu_checker u_xeu_checker (.*);

`default_nettype wire
